// File: rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg - shared types and constants of the 3x3 median filter
// pixel, window and queue item types, sorting network table and helper
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_LINE    = 1024;
    localparam int MAX_LINES   = 4096;
    localparam int PIX_W       = 8;
    localparam int COL_W       = 10;
    localparam int ROW_W       = 12;
    localparam int FWIDTH_W    = 11;
    localparam int FHEIGHT_W   = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int WIN_TAPS    = 9;
    localparam int MEDIAN_POS  = 4;
    localparam int NET_LEN     = 19;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;
    localparam int M_PAD_W     = M_TDATA_W - PIX_W - COL_W - ROW_W;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_FRAME_WIDTH  = cfg_index_t'(0);
    localparam cfg_index_t CFG_FRAME_HEIGHT = cfg_index_t'(1);

    typedef logic [PIX_W-1:0]             pixel_t;
    typedef logic [COL_W-1:0]             col_t;
    typedef logic [ROW_W-1:0]             row_t;
    typedef pixel_t [WIN_TAPS-1:0]        window_t;
    typedef logic [3:0]                   tap_idx_t;

    // frame geometry handed from the register block to the front end
    typedef struct packed {
        logic restart;
        col_t last_col;
        row_t last_row;
    } frame_cfg_t;

    // one complete window waiting for the median network
    typedef struct packed {
        window_t win;
        col_t    col;
        row_t    row;
        logic    done;
    } win_item_t;

    // 19-comparator median network: min goes to the first tap, max to the second
    localparam tap_idx_t NET_A [NET_LEN] = '{
        4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
        4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
    };
    localparam tap_idx_t NET_B [NET_LEN] = '{
        4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
        4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
    };

    // apply comparators first..last of the network to a window
    function automatic window_t sort_span(window_t w, int first, int last);
        window_t p;
        pixel_t  va;
        pixel_t  vb;
        p = w;
        for (int i = 0; i < NET_LEN; i++) begin
            if (i >= first && i <= last) begin
                va = p[NET_A[i]];
                vb = p[NET_B[i]];
                if (va > vb) begin
                    p[NET_A[i]] = vb;
                    p[NET_B[i]] = va;
                end
            end
        end
        return p;
    endfunction

endpackage

// File: rtl/core/mf3_front.sv
// ----------------------------------------------------------------------------
// mf3_front - pixel intake, line stores and sliding 3x3 window
// counts position, reads/writes the two line stores, pushes interior windows
// ----------------------------------------------------------------------------
module mf3_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  mf3_pkg::frame_cfg_t cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  mf3_pkg::pixel_t    s_pixel,
    input  logic               q_full,
    output logic               q_push,
    output mf3_pkg::win_item_t q_item
);
    import mf3_pkg::*;

    pixel_t  upper_mem [MAX_LINE];
    pixel_t  lower_mem [MAX_LINE];

    col_t    col_reg, col_next;
    row_t    row_reg, row_next;
    pixel_t  up_rd_reg, lo_rd_reg;

    logic    b_valid_reg, b_valid_next;
    pixel_t  b_px_reg;
    col_t    b_col_reg;
    row_t    b_row_reg;
    logic    b_interior_reg;
    logic    b_done_reg;

    window_t win_reg, win_next;
    logic    accept;
    logic    b_adv;

    assign b_adv    = b_valid_reg && !q_full;
    assign s_tready = !b_valid_reg || b_adv;
    assign accept   = s_tvalid && s_tready;

    // position counters
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg.restart) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (col_reg == cfg.last_col) begin
                col_next = '0;
                row_next = (row_reg == cfg.last_row) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb begin
        b_valid_next = b_valid_reg;
        if (accept) begin
            b_valid_next = 1'b1;
        end else if (b_adv) begin
            b_valid_next = 1'b0;
        end
    end

    // window shifts left, new column enters on the right
    always_comb begin
        win_next    = win_reg;
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_rd_reg;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = lo_rd_reg;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = b_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            win_reg     <= '0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            b_valid_reg <= b_valid_next;
            if (cfg.restart) begin
                win_reg <= '0;
            end else if (b_adv) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_px_reg       <= s_pixel;
            b_col_reg      <= col_reg;
            b_row_reg      <= row_reg;
            b_interior_reg <= (col_reg >= col_t'(2)) && (row_reg >= row_t'(2));
            b_done_reg     <= (col_reg == cfg.last_col) && (row_reg == cfg.last_row);
        end
    end

    // line stores: read on intake, older line moves up when the pixel leaves the front register
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            upper_mem[b_col_reg] <= lo_rd_reg;
            lower_mem[b_col_reg] <= b_px_reg;
        end
        if (accept) begin
            up_rd_reg <= upper_mem[col_reg];
            lo_rd_reg <= lower_mem[col_reg];
        end
    end

    assign q_push      = b_adv && b_interior_reg;
    assign q_item.win  = win_next;
    assign q_item.col  = b_col_reg - 1'b1;
    assign q_item.row  = b_row_reg - 1'b1;
    assign q_item.done = b_done_reg;

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.restart |=> (col_reg == '0) && (row_reg == '0))
        else $error("position counters not cleared after restart");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("window pushed into a full queue");

    a_col_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        !cfg.restart |-> col_reg <= cfg.last_col)
        else $error("column counter beyond line end");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && q_full |=> b_valid_reg && $stable(b_col_reg))
        else $error("stalled window stage lost its pixel");

endmodule

// File: rtl/core/mf3_queue.sv
// ----------------------------------------------------------------------------
// mf3_queue - short window queue between front end and median network
// register-based fifo with first-word fall-through output
// ----------------------------------------------------------------------------
module mf3_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mf3_pkg::win_item_t push_item,
    output logic               full,
    input  logic               pop,
    output mf3_pkg::win_item_t pop_item,
    output logic               empty
);
    import mf3_pkg::*;

    win_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count did not follow a push");

endmodule

// File: rtl/core/mf3_back.sv
// ----------------------------------------------------------------------------
// mf3_back - pipelined median network and result register
// three comparator stages, the last one is the output register
// ----------------------------------------------------------------------------
module mf3_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mf3_pkg::win_item_t               q_item,
    input  logic                             q_empty,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mf3_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                             m_tlast
);
    import mf3_pkg::*;

    win_item_t s1_reg, s2_reg;
    window_t   s3_win;
    logic      v1_reg, v2_reg, m_valid_reg;
    pixel_t    median_reg;
    col_t      col_reg;
    row_t      row_reg;
    logic      done_reg;
    logic      adv;

    // whole pipeline moves when the result register is free or being taken
    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;
    assign s3_win = sort_span(s2_reg.win, 12, NET_LEN - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= q_pop;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg.win  <= sort_span(q_item.win, 0, 5);
            s1_reg.col  <= q_item.col;
            s1_reg.row  <= q_item.row;
            s1_reg.done <= q_item.done;
            s2_reg.win  <= sort_span(s1_reg.win, 6, 11);
            s2_reg.col  <= s1_reg.col;
            s2_reg.row  <= s1_reg.row;
            s2_reg.done <= s1_reg.done;
            median_reg  <= s3_win[MEDIAN_POS];
            col_reg     <= s2_reg.col;
            row_reg     <= s2_reg.row;
            done_reg    <= s2_reg.done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, row_reg, col_reg, median_reg};
    assign m_tlast  = done_reg;

    a_pop_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> v1_reg)
        else $error("popped window missing from first stage");

    a_stage_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg && adv |=> m_valid_reg)
        else $error("last network stage did not reach the result register");

    a_no_pop_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !q_pop)
        else $error("queue popped while the result is held");

endmodule

// File: rtl/core/median_filter_3x3.sv
// ----------------------------------------------------------------------------
// median_filter_3x3 - streaming 3x3 median filter for 8-bit grayscale frames
// raster pixels in, one median per interior pixel out with its coordinates
// ----------------------------------------------------------------------------
//
//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------
//  s_ axis   | in        | tdata[7:0] pixel
//  m_ axis   | out       | tdata[7:0] median, [17:8] out_col, [29:18] out_row,
//            |           | tlast frame_done (last interior result of a frame)
//  cfg       | in        | index 0 frame_width (data[10:0]),
//            |           | index 1 frame_height (data[12:0])
//
//  one pixel per cycle sustained while the results are taken; m_tvalid rises
//  once the pixel transfer has passed the front register with line store read,
//  the queue, two network stages and the result register
//  the single read and write per cycle on each line store sets the rate
//  reset clears counters, window, queue and pipeline; line stores keep contents
//  a stalled result holds the network, the window queue (four deep) absorbs
//  the front end until it fills, then s_tready drops
//  a write to the width or height register restarts the frame at column 0, row 0
// ----------------------------------------------------------------------------
module median_filter_3x3 (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // pixel stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mf3_pkg::S_TDATA_W-1:0]        s_tdata,   // [7:0] pixel
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mf3_pkg::M_TDATA_W-1:0]        m_tdata,   // median, out_col, out_row
    output logic                                 m_tlast,   // frame_done
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  mf3_pkg::cfg_index_t                  cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mf3_pkg::*;

    logic [FWIDTH_W-1:0]  width_reg, width_next;
    logic [FHEIGHT_W-1:0] height_reg, height_next;
    logic [FWIDTH_W-1:0]  width_eff;
    logic [FHEIGHT_W-1:0] height_eff;
    logic                 cfg_fire;
    logic                 cfg_restart;
    frame_cfg_t           frame_cfg;

    logic                 q_full;
    logic                 q_push;
    win_item_t            q_in_item;
    logic                 q_pop;
    win_item_t            q_out_item;
    logic                 q_empty;

    // register writes are always taken
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // unknown indexes are ignored and do not restart the frame
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        cfg_restart = 1'b0;
        priority if (cfg_fire && cfg_index == CFG_FRAME_WIDTH) begin
            width_next  = cfg_data[FWIDTH_W-1:0];
            cfg_restart = 1'b1;
        end else if (cfg_fire && cfg_index == CFG_FRAME_HEIGHT) begin
            height_next = cfg_data[FHEIGHT_W-1:0];
            cfg_restart = 1'b1;
        end else begin
            width_next  = width_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FWIDTH_W'(320);
            height_reg <= FHEIGHT_W'(240);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // out-of-range sizes are clamped to the supported window
    always_comb begin
        if (width_reg < FWIDTH_W'(3)) begin
            width_eff = FWIDTH_W'(3);
        end else if (width_reg > FWIDTH_W'(MAX_LINE)) begin
            width_eff = FWIDTH_W'(MAX_LINE);
        end else begin
            width_eff = width_reg;
        end
        if (height_reg < FHEIGHT_W'(3)) begin
            height_eff = FHEIGHT_W'(3);
        end else if (height_reg > FHEIGHT_W'(MAX_LINES)) begin
            height_eff = FHEIGHT_W'(MAX_LINES);
        end else begin
            height_eff = height_reg;
        end
    end

    logic [FWIDTH_W-1:0]  width_m1;
    logic [FHEIGHT_W-1:0] height_m1;

    assign width_m1  = width_eff - 1'b1;
    assign height_m1 = height_eff - 1'b1;
    assign frame_cfg = '{restart:  cfg_restart,
                         last_col: width_m1[COL_W-1:0],
                         last_row: height_m1[ROW_W-1:0]};

    // front end: position, line stores, window
    mf3_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (frame_cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_pixel  (s_tdata[PIX_W-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_in_item)
    );

    // decoupling queue of complete windows
    mf3_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_in_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_out_item),
        .empty     (q_empty)
    );

    // back end: median network and result register
    mf3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_item   (q_out_item),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/tb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// tb_median_filter_3x3 - self-checking bench for the 3x3 median filter
// raster pixel transfers go in, every accepted result is compared with a behavioural
// window predictor or typed median; directed table first, then random and oversized frames
// ----------------------------------------------------------------------------
module tb_median_filter_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    // register indexes past the end of the map, writes to them are ignored
    localparam cfg_index_t CFG_SPARE_A = cfg_index_t'(2);
    localparam cfg_index_t CFG_SPARE_B = cfg_index_t'(3);

    localparam int SETTLE_CYCLES  = 12;      // pipeline is five deep, plus margin
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int RAND_PHASES    = 9;
    localparam int PRESSURE_PHASE = 1;
    localparam int EDGE_PIXELS    = 40;

    typedef logic [CFG_DATA_W-1:0] cfg_word_t;

    // one result as the filter should present it
    typedef struct packed {
        pixel_t median;
        col_t   col;
        row_t   row;
        logic   done;
    } filt_result_t;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_t;

    // one row of the directed table: a pixel transfer or a register write
    typedef struct {
        row_kind_t  kind;
        cfg_index_t idx;
        cfg_word_t  value;
        pixel_t     px;
        bit         typed;       // expected median written straight into the table
        pixel_t     typed_med;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and block ports, all inputs driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_index_t           cfg_index = CFG_FRAME_WIDTH;
    cfg_word_t            cfg_data  = '0;

    median_filter_3x3 dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [7:0] pixel
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // [7:0] median, [17:8] out_col, [29:18] out_row
        .m_tlast   (m_tlast),     // frame_done
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns period
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // window predictor: its own copy of the line stores, window and counters
    // ------------------------------------------------------------------------
    pixel_t               line_up [MAX_LINE];    // two lines above the pixel
    pixel_t               line_dn [MAX_LINE];    // one line above the pixel
    pixel_t               win_taps [WIN_TAPS];   // row-major, newest column on the right
    int                   cur_col;
    int                   cur_row;
    logic [FWIDTH_W-1:0]  width_cfg  = FWIDTH_W'(320);
    logic [FHEIGHT_W-1:0] height_cfg = FHEIGHT_W'(240);

    filt_result_t         pending_medians [$];   // medians still owed by the block
    stim_row_t            dir_tab [$];
    int                   faults      = 0;
    int                   cycle_count = 0;
    int                   send_idle_pct = 0;     // chance of a gap before each pixel
    int                   recv_idle_pct = 0;     // chance of m_tready low per cycle
    filt_result_t         seen_res;
    filt_result_t         want_res;

    function automatic int clamp_int(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        cur_col = 0;
        cur_row = 0;
        for (int i = 0; i < WIN_TAPS; i++) win_taps[i] = '0;
    endfunction

    // median by rank: the value with at most four below it and at least five at or below
    function automatic pixel_t rank_median();
        int lt;
        int le;
        for (int i = 0; i < WIN_TAPS; i++) begin
            lt = 0;
            le = 0;
            for (int j = 0; j < WIN_TAPS; j++) begin
                if (win_taps[j] < win_taps[i]) lt++;
                if (win_taps[j] <= win_taps[i]) le++;
            end
            if (lt <= MEDIAN_POS && le > MEDIAN_POS) return win_taps[i];
        end
        return '0;
    endfunction

    // advance the predictor by one pixel; returns 1 when a result is due
    function automatic bit slide_window(pixel_t px, output filt_result_t res);
        int     w;
        int     h;
        pixel_t above2;
        pixel_t above1;
        bit     hit;
        w = clamp_int(int'(width_cfg), 3, MAX_LINE);
        h = clamp_int(int'(height_cfg), 3, MAX_LINES);
        above2 = line_up[cur_col];
        above1 = line_dn[cur_col];
        line_up[cur_col] = above1;
        line_dn[cur_col] = px;
        for (int r = 0; r < 3; r++) begin
            win_taps[r*3]     = win_taps[r*3 + 1];
            win_taps[r*3 + 1] = win_taps[r*3 + 2];
        end
        win_taps[2] = above2;
        win_taps[5] = above1;
        win_taps[8] = px;
        res = '0;
        hit = 1'b0;
        // only interior centres give a result
        if (cur_col >= 2 && cur_row >= 2) begin
            res.median = rank_median();
            res.col    = col_t'(cur_col - 1);
            res.row    = row_t'(cur_row - 1);
            res.done   = (cur_col == w - 1) && (cur_row == h - 1);
            hit        = 1'b1;
        end
        cur_col++;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= h) cur_row = 0;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // directed table rows
    // ------------------------------------------------------------------------
    function automatic stim_row_t pix_row(pixel_t px, bit typed = 1'b0, pixel_t med = '0);
        stim_row_t row;
        row.kind      = ROW_PIX;
        row.idx       = CFG_FRAME_WIDTH;
        row.value     = '0;
        row.px        = px;
        row.typed     = typed;
        row.typed_med = med;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(cfg_index_t idx, cfg_word_t value);
        stim_row_t row;
        row           = pix_row('0);
        row.kind      = ROW_CFG;
        row.idx       = idx;
        row.value     = value;
        return row;
    endfunction

    // mostly random, with extremes and near-ties around a level
    function automatic pixel_t rand_pixel(pixel_t level);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return level ^ pixel_t'($urandom_range(0, 3));
            default: return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // drive tasks: enter and leave at a falling edge, handshake seen at rising
    // ------------------------------------------------------------------------
    task automatic push_pixel(pixel_t px, bit typed, pixel_t typed_med);
        filt_result_t res;
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = px;
        do @(posedge aclk); while (!s_tready);
        // transfer taken, work out what it owes
        if (slide_window(px, res)) begin
            if (typed) res.median = typed_med;
            pending_medians.push_back(res);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, cfg_word_t value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH: begin
                width_cfg = value[FWIDTH_W-1:0];
                restart_frame();
            end
            CFG_FRAME_HEIGHT: begin
                height_cfg = value[FHEIGHT_W-1:0];
                restart_frame();
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // sender holds off until every owed median has been seen
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending_medians.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drained, then let a border pixel still in flight leave the pipeline
    task automatic wait_settled();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // result side: random back-pressure, and the checker
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        m_tready = (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_res.median = m_tdata[PIX_W-1:0];
            seen_res.col    = m_tdata[PIX_W+COL_W-1:PIX_W];
            seen_res.row    = m_tdata[PIX_W+COL_W+ROW_W-1:PIX_W+COL_W];
            seen_res.done   = m_tlast;
            if (pending_medians.size() == 0) begin
                faults++;
                if (faults <= MAX_REPORTS)
                    $display("unexpected result: median %0d col %0d row %0d last %0b",
                             seen_res.median, seen_res.col, seen_res.row, seen_res.done);
            end else begin
                want_res = pending_medians.pop_front();
                if (seen_res.median !== want_res.median || seen_res.col !== want_res.col ||
                    seen_res.row !== want_res.row || seen_res.done !== want_res.done) begin
                    faults++;
                    if (faults <= MAX_REPORTS)
                        $display("mismatch: expected median %0d col %0d row %0d last %0b, %s",
                                 want_res.median, want_res.col, want_res.row, want_res.done,
                                 $sformatf("got median %0d col %0d row %0d last %0b",
                                           seen_res.median, seen_res.col, seen_res.row,
                                           seen_res.done));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("median_filter_3x3 regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int     w_raw;
        int     h_raw;
        int     w_eff;
        int     h_eff;
        int     n_pix;
        pixel_t level;

        // 3x3 frame from undersized register values: 0 acts as 3, 1 acts as 3
        dir_tab.push_back(cfg_row(CFG_FRAME_WIDTH, cfg_word_t'(0)));
        dir_tab.push_back(cfg_row(CFG_FRAME_HEIGHT, cfg_word_t'(1)));
        // flat white frame, one interior result, last of the frame
        for (int i = 0; i < 9; i++) dir_tab.push_back(pix_row(8'hFF, i == 8, 8'hFF));
        // black frame, interrupted by a write to an unmapped index which must not restart it
        for (int i = 0; i < 2; i++) dir_tab.push_back(pix_row(8'h00));
        dir_tab.push_back(cfg_row(CFG_SPARE_B, '1));
        for (int i = 0; i < 7; i++) dir_tab.push_back(pix_row(8'h00, i == 6, 8'h00));
        // one stray pixel, then a width write that restarts the frame
        dir_tab.push_back(pix_row(8'hFF));
        dir_tab.push_back(cfg_row(CFG_FRAME_WIDTH, cfg_word_t'(2)));
        dir_tab.push_back(pix_row(8'd200));
        dir_tab.push_back(pix_row(8'd10));
        dir_tab.push_back(pix_row(8'd128));
        dir_tab.push_back(pix_row(8'd255));
        dir_tab.push_back(pix_row(8'd0));
        dir_tab.push_back(pix_row(8'd77));
        dir_tab.push_back(pix_row(8'd1));
        dir_tab.push_back(pix_row(8'd254));
        dir_tab.push_back(pix_row(8'd99));

        // predictor starts from the reset state
        restart_frame();

        // reset held low from time zero, released at a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // first schedule: sender gaps in a third of the slots, receiver stalls most
        send_idle_pct = 33;
        recv_idle_pct = 71;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_settled();
                write_reg(dir_tab[i].idx, dir_tab[i].value);
            end else begin
                push_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].typed_med);
            end
        end

        // random frames of small size, each phase with fresh geometry
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p == 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 33;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            w_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            h_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            wait_settled();
            // upper data bits above the width field are dont-care
            if ($urandom_range(0, 1)) begin
                write_reg(CFG_FRAME_WIDTH,
                          cfg_word_t'({2'($urandom_range(0, 3)), FWIDTH_W'(w_raw)}));
                write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(h_raw));
            end else begin
                write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(h_raw));
                write_reg(CFG_FRAME_WIDTH,
                          cfg_word_t'({2'($urandom_range(0, 3)), FWIDTH_W'(w_raw)}));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          cfg_word_t'($urandom));
            w_eff = clamp_int(w_raw, 3, MAX_LINE);
            h_eff = clamp_int(h_raw, 3, MAX_LINES);
            n_pix = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, 2 * w_eff);
            level = pixel_t'($urandom_range(0, 255));
            for (int i = 0; i < n_pix; i++) begin
                // once, the sender stops mid-frame until the result stream is empty
                if (p == PRESSURE_PHASE && i == n_pix / 2) wait_drained();
                push_pixel(rand_pixel(level), 1'b0, '0);
            end
        end

        // oversized width: 2047 acts as 1024, a short run stays on the first line
        wait_settled();
        write_reg(CFG_FRAME_WIDTH, cfg_word_t'(13'h07FF));
        write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(13'h0003));
        for (int i = 0; i < EDGE_PIXELS; i++)
            push_pixel(pixel_t'($urandom_range(0, 255)), 1'b0, '0);

        // width field reads as 0 once masked, 8191 lines act as 4096
        wait_settled();
        write_reg(CFG_FRAME_WIDTH, cfg_word_t'(13'h1800));
        write_reg(CFG_FRAME_HEIGHT, cfg_word_t'(13'h1FFF));
        for (int i = 0; i < EDGE_PIXELS; i++)
            push_pixel(pixel_t'($urandom_range(0, 255)), 1'b0, '0);

        // drain and let the pipeline run dry
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        faults += pending_medians.size();
        if (faults == 0) begin
            $display("median_filter_3x3 regression: pass");
        end else begin
            $display("median_filter_3x3 regression: fail");
        end
        $finish;
    end

endmodule
